// ===== src/bhp_pkg.sv =====
// Shared types, codes and field-size helpers for the bitmap header parser.
// Used by bhp_core and by the top level bitmap_header_parser; no dependencies.
package bhp_pkg;

    localparam int BHP_LONG_ADDR_BYTES = 16;
    localparam int NUM_FIELDS = 8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ESP   = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [15:0] present_flags;
        logic [7:0]  version_value;
        logic [31:0] dest_address;
        logic [15:0] length_value;
        logic [7:0]  ttl_value;
        logic [31:0] flow_value;
        logic [31:0] source_address;
        logic [7:0]  protocol_value;
        logic [15:0] checksum_value;
        logic [5:0]  payload_offset;
    } t_result;

    function automatic logic [4:0] f_addr_size(input logic [1:0] code, input int long_bytes);
        logic [4:0] size;
        case (code)
            2'd1:    size = 5'd2;
            2'd2:    size = 5'd4;
            2'd3:    size = 5'(long_bytes);
            default: size = 5'd0;
        endcase
        return size;
    endfunction

    function automatic logic [4:0] f_field_size(input logic [2:0] step,
                                                input logic [15:0] bitmap,
                                                input logic [1:0] dcode,
                                                input logic [1:0] scode,
                                                input int long_bytes);
        logic [4:0] size;
        case (step)
            3'd0:    size = bitmap[13] ? 5'd1 : 5'd0;
            3'd1:    size = f_addr_size(dcode, long_bytes);
            3'd2:    size = bitmap[10] ? 5'd2 : 5'd0;
            3'd3:    size = bitmap[9] ? 5'd1 : 5'd0;
            3'd4:    size = bitmap[8] ? 5'd4 : 5'd0;
            3'd5:    size = f_addr_size(scode, long_bytes);
            3'd6:    size = bitmap[4] ? 5'd1 : 5'd0;
            3'd7:    size = bitmap[3] ? 5'd2 : 5'd0;
            default: size = 5'd0;
        endcase
        return size;
    endfunction

    // Returns the first present field at or after start, or NUM_FIELDS if none is left.
    function automatic logic [3:0] f_skip(input logic [3:0] start,
                                          input logic [15:0] bitmap,
                                          input logic [1:0] dcode,
                                          input logic [1:0] scode,
                                          input int long_bytes);
        logic [3:0] res;
        res = 4'(NUM_FIELDS);
        for (int k = NUM_FIELDS - 1; k >= 0; k--) begin
            if (4'(k) >= start &&
                f_field_size(3'(k), bitmap, dcode, scode, long_bytes) != 5'd0) begin
                res = 4'(k);
            end
        end
        return res;
    endfunction

endpackage

// ===== src/bhp_core.sv =====
// Parse state and per-byte update of the bitmap header parser.
// Depends on bhp_pkg; instantiated by bitmap_header_parser.
module bhp_core import bhp_pkg::*; #(
    parameter int LONG_ADDR_BYTES = BHP_LONG_ADDR_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data,
    input  logic       i_first,
    input  logic       i_last,
    output t_result    o_res
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_BITMAP2 = 3'd1;
    localparam logic [2:0] PH_FIELDS  = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_bitmap, n_bitmap;
    logic [3:0]  r_step, n_step;
    logic [4:0]  r_fbc, n_fbc;
    logic [5:0]  r_hcnt, n_hcnt;
    logic [1:0]  r_dcode, n_dcode;
    logic [1:0]  r_scode, n_scode;
    logic [31:0] r_acc [NUM_FIELDS];
    logic [31:0] n_acc [NUM_FIELDS];

    logic        w_emit;
    logic [1:0]  w_status;
    logic [2:0]  w_idx;
    logic [4:0]  w_size;
    logic [4:0]  w_fbc_inc;
    logic        w_long;
    logic [31:0] w_val [NUM_FIELDS];

    always_comb begin
        n_phase  = r_phase;
        n_bitmap = r_bitmap;
        n_step   = r_step;
        n_fbc    = r_fbc;
        n_hcnt   = r_hcnt;
        n_dcode  = r_dcode;
        n_scode  = r_scode;
        n_acc    = r_acc;
        w_emit   = 1'b0;
        w_status = ST_OK;
        w_idx    = r_step[2:0];
        w_size   = f_field_size(w_idx, r_bitmap, r_dcode, r_scode, LONG_ADDR_BYTES);
        w_long   = (w_idx == 3'd1 && r_dcode == 2'd3) || (w_idx == 3'd5 && r_scode == 2'd3);
        w_fbc_inc = r_fbc + 5'd1;
        if (i_step) begin
            if (i_first) begin
                for (int k = 0; k < NUM_FIELDS; k++) begin
                    n_acc[k] = '0;
                end
                n_hcnt   = 6'd1;
                n_bitmap = {i_data, 8'h00};
                n_step   = 4'd0;
                n_fbc    = 5'd0;
                n_dcode  = 2'd0;
                n_scode  = 2'd0;
                if (i_data[6]) begin
                    w_emit   = 1'b1;
                    w_status = ST_ESP;
                end else begin
                    n_dcode = i_data[4:3];
                    if (i_data[7]) begin
                        n_phase = PH_BITMAP2;
                    end else begin
                        n_step = f_skip(4'd0, n_bitmap, n_dcode, 2'd0, LONG_ADDR_BYTES);
                        if (n_step[3]) begin
                            w_emit = 1'b1;
                        end else begin
                            n_phase = PH_FIELDS;
                        end
                    end
                end
            end else if (r_phase == PH_BITMAP2) begin
                n_hcnt   = r_hcnt + 6'd1;
                n_bitmap = {r_bitmap[15:8], i_data};
                n_scode  = i_data[6:5];
                n_step   = f_skip(4'd0, n_bitmap, r_dcode, n_scode, LONG_ADDR_BYTES);
                if (n_step[3]) begin
                    w_emit = 1'b1;
                end else begin
                    n_phase = PH_FIELDS;
                end
            end else if (r_phase == PH_FIELDS) begin
                n_hcnt = r_hcnt + 6'd1;
                if (!w_long) begin
                    n_acc[w_idx] = {r_acc[w_idx][23:0], i_data};
                end
                if (w_fbc_inc >= w_size) begin
                    n_fbc  = 5'd0;
                    n_step = f_skip(r_step + 4'd1, r_bitmap, r_dcode, r_scode,
                                    LONG_ADDR_BYTES);
                    if (n_step[3]) begin
                        w_emit = 1'b1;
                    end
                end else begin
                    n_fbc = w_fbc_inc;
                end
            end
            if (!w_emit && i_last &&
                (i_first || r_phase inside {PH_BITMAP2, PH_FIELDS})) begin
                w_emit   = 1'b1;
                w_status = ST_SHORT;
            end
            if (w_emit) begin
                n_phase = PH_DONE;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_FIELDS; k++) begin
            w_val[k] = (4'(k) < n_step) ? n_acc[k] : 32'd0;
        end
        o_res.valid          = w_emit;
        o_res.status         = w_status;
        o_res.present_flags  = n_bitmap;
        o_res.version_value  = w_val[0][7:0];
        o_res.dest_address   = w_val[1];
        o_res.length_value   = w_val[2][15:0];
        o_res.ttl_value      = w_val[3][7:0];
        o_res.flow_value     = w_val[4];
        o_res.source_address = w_val[5];
        o_res.protocol_value = w_val[6][7:0];
        o_res.checksum_value = w_val[7][15:0];
        o_res.payload_offset = n_hcnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bitmap <= '0;
            r_step   <= '0;
            r_fbc    <= '0;
            r_hcnt   <= '0;
            r_dcode  <= '0;
            r_scode  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_bitmap <= n_bitmap;
            r_step   <= n_step;
            r_fbc    <= n_fbc;
            r_hcnt   <= n_hcnt;
            r_dcode  <= n_dcode;
            r_scode  <= n_scode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule

// ===== src/bitmap_header_parser.sv =====
// Bitmap header parser, top level: input register, parse core and result register.
// Depends on bhp_pkg and bhp_core.
//
// The block takes one packet byte per cycle and reports one request per packet header:
// when the header is complete, when the first bitmap byte marks an ESP packet, or when
// the packet ends inside the header. Each byte passes an input register, the parse
// update and a result register, so the result is offered once the byte that completes
// it has passed both registers, and a new byte is taken in every cycle while the output
// side accepts.
// Back-pressure on the output stalls both stages; bytes outside a packet are dropped.
module bitmap_header_parser import bhp_pkg::*; #(
    parameter int LONG_ADDR_BYTES = BHP_LONG_ADDR_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tuser,   // first_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // present_flags, version_value, dest_address, length_value, ttl_value, flow_value,
    // source_address, protocol_value, checksum_value, payload_offset, two zero bits
    output logic [175:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser    // status
);

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_first;
    logic       r_in_last;
    logic       w_adv;
    t_result    w_res;
    t_result    r_out;

    assign w_adv         = !r_out.valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data  <= s_axis_tdata;
            r_in_first <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
        end
    end

    bhp_core #(
        .LONG_ADDR_BYTES(LONG_ADDR_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (r_in_valid && w_adv),
        .i_data  (r_in_data),
        .i_first (r_in_first),
        .i_last  (r_in_last),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_adv) begin
            r_out.valid <= w_res.valid;
            if (w_res.valid) begin
                r_out.status         <= w_res.status;
                r_out.present_flags  <= w_res.present_flags;
                r_out.version_value  <= w_res.version_value;
                r_out.dest_address   <= w_res.dest_address;
                r_out.length_value   <= w_res.length_value;
                r_out.ttl_value      <= w_res.ttl_value;
                r_out.flow_value     <= w_res.flow_value;
                r_out.source_address <= w_res.source_address;
                r_out.protocol_value <= w_res.protocol_value;
                r_out.checksum_value <= w_res.checksum_value;
                r_out.payload_offset <= w_res.payload_offset;
            end
        end
    end

    assign m_axis_tvalid = r_out.valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {2'b00, r_out.payload_offset, r_out.checksum_value,
                            r_out.protocol_value, r_out.source_address, r_out.flow_value,
                            r_out.ttl_value, r_out.length_value, r_out.dest_address,
                            r_out.version_value, r_out.present_flags};

    // A stalled result is never dropped or replaced.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid && !m_axis_tready |=> r_out.valid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An ESP result carries only the first bitmap byte and a length of one.
    a_esp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid && r_out.status == ST_ESP |->
            r_out.payload_offset == 6'd1 && r_out.present_flags[7:0] == 8'h00 &&
            r_out.version_value == 8'h00 && r_out.flow_value == 32'd0)
        else $error("malformed ESP result");

    // The header length always lies between one byte and the longest header.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid |->
            r_out.payload_offset != 6'd0 &&
            r_out.payload_offset <= 6'(13 + 2 * LONG_ADDR_BYTES))
        else $error("header length out of range");

    // The input stage cannot be refilled while its byte is still waiting.
    a_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |-> !s_axis_tready)
        else $error("input stage overrun");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_header_parser: byte-stream driver, result monitor
// and a cycle-free parse predictor. Depends on bhp_pkg and the bitmap_header_parser RTL.
module tb import bhp_pkg::*; ();

    localparam int CALM_TAIL   = 150;
    localparam int TARGET_REQS = 1500;

    typedef enum logic [1:0] {P_IDLE, P_BITMAP2, P_FIELDS, P_DONE} t_parse_phase;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
        bit         hold;
    } t_byte_req;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] flags;
        logic [7:0]  version;
        logic [31:0] dest;
        logic [15:0] length;
        logic [7:0]  ttl;
        logic [31:0] flow;
        logic [31:0] source;
        logic [7:0]  protocol;
        logic [15:0] checksum;
        logic [5:0]  hlen;
    } t_header_fields;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;   // data_byte
    logic         s_axis_tuser = 1'b0;    // first_byte
    logic         s_axis_tlast = 1'b0;    // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // present_flags, version_value, dest_address, length_value, ttl_value, flow_value,
    // source_address, protocol_value, checksum_value, payload_offset, two zero bits
    logic [175:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;           // status

    t_byte_req      byte_stream[$];
    t_header_fields header_expect[$];
    int             errors = 0;
    bit             in_taken = 1'b0;
    int             in_gap = 0;
    int             out_gap = 0;

    t_parse_phase   hp_phase = P_IDLE;
    logic [15:0]    hp_flags = '0;
    int             hp_step = 0;
    int             hp_fcount = 0;
    logic [5:0]     hp_hlen = '0;
    logic [1:0]     hp_dcode = '0;
    logic [1:0]     hp_scode = '0;
    logic [31:0]    hp_acc [8];

    bitmap_header_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int addr_len(input logic [1:0] code);
        case (code)
            2'd1:    return 2;
            2'd2:    return 4;
            2'd3:    return BHP_LONG_ADDR_BYTES;
            default: return 0;
        endcase
    endfunction

    function automatic int field_len(input int idx);
        case (idx)
            0:       return hp_flags[13] ? 1 : 0;
            1:       return addr_len(hp_dcode);
            2:       return hp_flags[10] ? 2 : 0;
            3:       return hp_flags[9] ? 1 : 0;
            4:       return hp_flags[8] ? 4 : 0;
            5:       return addr_len(hp_scode);
            6:       return hp_flags[4] ? 1 : 0;
            7:       return hp_flags[3] ? 2 : 0;
            default: return 0;
        endcase
    endfunction

    function automatic int header_bytes(input logic [7:0] b1, input logic [7:0] b2);
        int n;
        if (b1[6]) begin
            return 1;
        end
        n = b1[7] ? 2 : 1;
        n += (b1[5] ? 1 : 0) + addr_len(b1[4:3]) + (b1[2] ? 2 : 0) + (b1[1] ? 1 : 0)
             + (b1[0] ? 4 : 0);
        if (b1[7]) begin
            n += addr_len(b2[6:5]) + (b2[4] ? 1 : 0) + (b2[3] ? 2 : 0);
        end
        return n;
    endfunction

    task automatic skip_absent();
        while (hp_step < NUM_FIELDS && field_len(hp_step) == 0) begin
            hp_step++;
        end
    endtask

    task automatic record_header(input logic [1:0] status);
        logic [31:0]    v [8];
        t_header_fields r;
        for (int k = 0; k < NUM_FIELDS; k++) begin
            v[k] = (status != ST_ESP && k < hp_step) ? hp_acc[k] : 32'd0;
        end
        r.status   = status;
        r.flags    = hp_flags;
        r.version  = v[0][7:0];
        r.dest     = v[1];
        r.length   = v[2][15:0];
        r.ttl      = v[3][7:0];
        r.flow     = v[4];
        r.source   = v[5];
        r.protocol = v[6][7:0];
        r.checksum = v[7][15:0];
        r.hlen     = hp_hlen;
        header_expect.push_back(r);
        hp_phase = P_DONE;
    endtask

    task automatic parse_byte(input logic [7:0] d, input logic first, input logic last);
        bit used;
        bit done;
        int idx;
        int size;
        bit is_long;
        used = 1'b1;
        done = 1'b0;
        if (first) begin
            hp_phase  = P_IDLE;
            hp_step   = 0;
            hp_fcount = 0;
            hp_dcode  = '0;
            hp_scode  = '0;
            foreach (hp_acc[k]) hp_acc[k] = '0;
            hp_hlen   = 6'd1;
            hp_flags  = {d, 8'h00};
            if (d[6]) begin
                record_header(ST_ESP);
                done = 1'b1;
            end else begin
                hp_dcode = d[4:3];
                if (d[7]) begin
                    hp_phase = P_BITMAP2;
                end else begin
                    skip_absent();
                    if (hp_step >= NUM_FIELDS) begin
                        record_header(ST_OK);
                        done = 1'b1;
                    end else begin
                        hp_phase = P_FIELDS;
                    end
                end
            end
        end else if (hp_phase == P_BITMAP2) begin
            hp_hlen++;
            hp_flags[7:0] = d;
            hp_scode = d[6:5];
            hp_step = 0;
            skip_absent();
            if (hp_step >= NUM_FIELDS) begin
                record_header(ST_OK);
                done = 1'b1;
            end else begin
                hp_phase = P_FIELDS;
            end
        end else if (hp_phase == P_FIELDS) begin
            idx = hp_step;
            size = field_len(idx);
            is_long = (idx == 1 && hp_dcode == 2'd3) || (idx == 5 && hp_scode == 2'd3);
            hp_hlen++;
            if (!is_long) begin
                hp_acc[idx] = {hp_acc[idx][23:0], d};
            end
            hp_fcount++;
            if (hp_fcount >= size) begin
                hp_fcount = 0;
                hp_step++;
                skip_absent();
                if (hp_step >= NUM_FIELDS) begin
                    record_header(ST_OK);
                    done = 1'b1;
                end
            end
        end else begin
            used = 1'b0;
        end
        if (used && !done && last) begin
            record_header(ST_SHORT);
        end
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_header(input logic [175:0] td, input logic [1:0] tu);
        t_header_fields e;
        if (header_expect.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %h data %h",
                     $time, tu, td);
            errors++;
        end else begin
            e = header_expect.pop_front();
            cmp_field("status", 32'(e.status), 32'(tu));
            cmp_field("present_flags", 32'(e.flags), 32'(td[15:0]));
            cmp_field("version_value", 32'(e.version), 32'(td[23:16]));
            cmp_field("dest_address", e.dest, td[55:24]);
            cmp_field("length_value", 32'(e.length), 32'(td[71:56]));
            cmp_field("ttl_value", 32'(e.ttl), 32'(td[79:72]));
            cmp_field("flow_value", e.flow, td[111:80]);
            cmp_field("source_address", e.source, td[143:112]);
            cmp_field("protocol_value", 32'(e.protocol), 32'(td[151:144]));
            cmp_field("checksum_value", 32'(e.checksum), 32'(td[167:152]));
            cmp_field("payload_offset", 32'(e.hlen), 32'(td[173:168]));
            cmp_field("padding", 32'd0, 32'(td[175:174]));
        end
    endtask

    task automatic push_byte(input logic [7:0] d, input logic first, input logic last,
                             input bit hold);
        t_byte_req r;
        r.data  = d;
        r.first = first;
        r.last  = last;
        r.hold  = hold;
        byte_stream.push_back(r);
    endtask

    // A cut index inside the packet truncates it there; without ends no byte carries last.
    task automatic add_packet(input logic [7:0] b1, input logic [7:0] b2, input int payload,
                              input int cut, input bit ends, input bit hold);
        int total;
        int n;
        int fill;
        logic [7:0] d;
        total = header_bytes(b1, b2) + payload;
        n = (cut >= 0 && cut < total) ? cut + 1 : total;
        fill = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin
                d = b1;
            end else if (i == 1 && b1[7] && !b1[6]) begin
                d = b2;
            end else if (fill == 0) begin
                d = 8'h00;
            end else if (fill == 1) begin
                d = 8'hFF;
            end else begin
                d = 8'($urandom_range(0, 255));
            end
            push_byte(d, i == 0, ends && i == n - 1, hold && i == 0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_header(m_axis_tdata, m_axis_tuser);
            end
        end
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    always @(negedge i_clk) begin : byte_driver
        t_byte_req r;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (byte_stream.size() == 0 ||
                         (byte_stream[0].hold && header_expect.size() != 0)) begin
                s_axis_tvalid <= 1'b0;
            end else if (byte_stream.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                in_gap <= $urandom_range(0, 3);
                s_axis_tvalid <= 1'b0;
            end else begin
                r = byte_stream.pop_front();
                s_axis_tdata  <= r.data;
                s_axis_tuser  <= r.first;
                s_axis_tlast  <= r.last;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (byte_stream.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            out_gap <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int kind;
        int hb;
        logic [7:0] b1;
        logic [7:0] b2;
        // Stray byte before any packet, then ESP with a trailing byte that is dropped.
        push_byte(8'hFF, 1'b0, 1'b1, 1'b0);
        push_byte(8'hC0, 1'b1, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1, 1'b0);
        // Empty bitmap on a one-byte packet; second bitmap byte with only ignored bits.
        push_byte(8'h00, 1'b1, 1'b1, 1'b0);
        push_byte(8'h80, 1'b1, 1'b0, 1'b0);
        push_byte(8'h87, 1'b0, 1'b1, 1'b0);
        // Packet ends inside the length field.
        push_byte(8'h24, 1'b1, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b0, 1'b0, 1'b0);
        push_byte(8'h12, 1'b0, 1'b1, 1'b0);
        // Restart in the middle of a header, then a payload byte after the result.
        push_byte(8'h04, 1'b1, 1'b0, 1'b0);
        push_byte(8'h11, 1'b0, 1'b0, 1'b0);
        push_byte(8'h20, 1'b1, 1'b0, 1'b0);
        push_byte(8'h5A, 1'b0, 1'b0, 1'b0);
        push_byte(8'h33, 1'b0, 1'b1, 1'b0);
        // Two-byte destination of all ones, complete on the last byte, sent only after
        // every earlier result has come back.
        push_byte(8'h08, 1'b1, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1, 1'b0);
        // Two-byte source with a final ESP byte carrying every bitmap bit.
        push_byte(8'h80, 1'b1, 1'b0, 1'b0);
        push_byte(8'h20, 1'b0, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0, 1'b0);
        push_byte(8'h02, 1'b0, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b1, 1'b0);

        while (byte_stream.size() < TARGET_REQS) begin
            b1 = 8'($urandom_range(0, 255));
            b2 = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) != 0) begin
                b1[6] = 1'b0;
            end
            hb = header_bytes(b1, b2);
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                add_packet(b1, b2, $urandom_range(0, 3), -1, 1'b1,
                           $urandom_range(0, 19) == 0);
            end else if (kind < 80) begin
                add_packet(b1, b2, 0, $urandom_range(0, hb - 1), 1'b1, 1'b0);
            end else if (kind < 92) begin
                add_packet(b1, b2, 0, $urandom_range(0, hb - 1), 1'b0, 1'b0);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                              1'b0);
                end
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_stream.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (header_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
